>>> src/thnt_pkg.sv
// ----------------------------------------------------------------------------
// Two-hop neighbor table package
// Shared types and constants of the two-hop neighbor table.
// ----------------------------------------------------------------------------
`default_nettype none
package thnt_pkg;
   localparam int MaxNeighbors     = 16;
   localparam int MaxFarNodes      = 16;
   localparam int LinksPerNeighbor = 16;
   localparam int NbIdxW   = $clog2(MaxNeighbors);
   localparam int FarIdxW  = $clog2(MaxFarNodes);
   localparam int LinkIdxW = $clog2(LinksPerNeighbor);
   localparam int NbCntW   = $clog2(MaxNeighbors + 1);
   localparam int FarCntW  = $clog2(MaxFarNodes + 1);
   localparam int LinkCntW = $clog2(LinksPerNeighbor + 1);

   localparam logic [31:0] CostMax = 32'hFFFF_FFFF;
   localparam logic [31:0] AgeStep = 32'h1000_0000;

   typedef enum logic [1:0] {
      MODE_NB_REPORT  = 2'd0,
      MODE_TWO_HOP    = 2'd1,
      MODE_AGE_TICK   = 2'd2,
      MODE_MPR_NOTICE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_UNKNOWN  = 2'd2,
      ST_OWN_ADDR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_NODE_ADDRESS = 2'd0,
      CSR_ENERGY_CAP   = 2'd1,
      CSR_COST_MULT    = 2'd2,
      CSR_LINK_DELAY   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DIV, S_NB_SCAN, S_NB_DONE, S_FAR_SCAN, S_FAR_DONE,
      S_LINK_SCAN, S_LINK_DONE, S_AGE_RD, S_AGE_WR, S_OUT
   } state_type;
endpackage
`default_nettype wire

>>> src/two_hop_neighbor_table_top.sv
// ----------------------------------------------------------------------------
// Two-hop neighbor table
// Neighbor table for mesh routing: link cost, two-hop links, aging, MPR marks.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on req_ (tdata: mode, neighbor_id, energy, far_id); each
// gives one result item on rsp_ (tdata: status, entry_index, link_cost).
// Registers are written on csr_; the user must write them only while the
// block is idle; the block itself does not enforce this. One item is handled
// at a time. Entries are scanned one per cycle through a memory with a
// registered read port. A neighbor report also runs a restoring divider after
// a multiply step. A two-hop report scans neighbors, far nodes and the
// sender's links. An aging tick reads and writes back each stored neighbor in
// turn. An MPR notice takes the neighbor scan only.
// The result sits in an output register until rsp_tready; no new item is
// taken until it leaves. Reset empties both tables (counts go to zero) and
// loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module two_hop_neighbor_table_top
   import thnt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // mode[1:0], neighbor_id[17:2], energy[49:18], far_id[65:50]
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], entry_index[5:2], link_cost[37:6]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   // Neighbor record: id, cost, flags, link count.
   localparam int NbRecW = 16 + 32 + 2 + LinkCntW;

   logic [15:0] node_addr_ff;
   logic [31:0] energy_cap_ff, cost_mult_ff, link_delay_ff;

   state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [15:0] nid_ff, fid_ff;
   logic [31:0] energy_ff;
   logic [31:0] cost_ff;
   logic [63:0] rem_ff;
   logic [5:0]  dcnt_ff;
   logic [NbCntW-1:0]   nb_count_ff;
   logic [FarCntW-1:0]  far_count_ff;
   logic [NbCntW-1:0]   scan_ff;
   logic                hit_ff;
   logic [NbIdxW-1:0]   nb_idx_ff;
   logic [FarIdxW-1:0]  far_idx_ff;
   logic [1:0]  st_ff;
   logic [3:0]  idx_out_ff;
   logic [31:0] cost_out_ff;
   logic        rsp_valid_ff;
   logic        rd_pend_ff;

   // Memories
   logic [NbRecW-1:0]  nb_mem [MaxNeighbors];
   logic [15:0]        far_mem [MaxFarNodes];
   logic [FarIdxW-1:0] link_mem [MaxNeighbors*LinksPerNeighbor];
   logic [NbRecW-1:0]  nb_rd_ff;
   logic [15:0]        far_rd_ff;
   logic [FarIdxW-1:0] link_rd_ff;

   logic               nb_we;
   logic [NbIdxW-1:0]  nb_waddr, nb_raddr;
   logic [NbRecW-1:0]  nb_wdata;
   logic               far_we;
   logic [FarIdxW-1:0] far_raddr;
   logic               link_we;
   logic [NbIdxW+LinkIdxW-1:0] link_waddr, link_raddr;

   logic [15:0]         rd_id;
   logic [31:0]         rd_cost;
   logic [1:0]          rd_flags;
   logic [LinkCntW-1:0] rd_lcnt;
   assign {rd_id, rd_cost, rd_flags, rd_lcnt} = nb_rd_ff;

   always_ff @(posedge clock) begin
      if (nb_we) nb_mem[nb_waddr] <= nb_wdata;
      nb_rd_ff <= nb_mem[nb_raddr];
      if (far_we) far_mem[far_count_ff[FarIdxW-1:0]] <= fid_ff;
      far_rd_ff <= far_mem[far_raddr];
      if (link_we) link_mem[link_waddr] <= far_idx_ff;
      link_rd_ff <= link_mem[link_raddr];
   end

   logic [31:0] capped;
   assign capped = (energy_ff > energy_cap_ff) ? energy_cap_ff : energy_ff;

   // The shifted partial remainder needs 33 bits when the divisor is large.
   logic [32:0] dtrial;
   assign dtrial = rem_ff[63:31] - {1'b0, link_delay_ff};

   logic scan_end, nb_full, far_full;
   assign nb_full  = nb_count_ff == NbCntW'(MaxNeighbors);
   assign far_full = far_count_ff == FarCntW'(MaxFarNodes);

   // Next-state and memory control
   logic [NbCntW-1:0] scan_in;
   logic hit_in, rd_pend_in;
   logic [NbIdxW-1:0] nb_idx_in;
   logic [FarIdxW-1:0] far_idx_in;
   logic [NbCntW-1:0] nb_count_in;
   logic [FarCntW-1:0] far_count_in;
   logic [1:0] st_in;
   logic [3:0] idx_out_in;
   logic [31:0] cost_out_in;
   logic rsp_valid_in;
   logic accept;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      rd_pend_in   = 1'b0;
      nb_idx_in    = nb_idx_ff;
      far_idx_in   = far_idx_ff;
      nb_count_in  = nb_count_ff;
      far_count_in = far_count_ff;
      st_in        = st_ff;
      idx_out_in   = idx_out_ff;
      cost_out_in  = cost_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      nb_we        = 1'b0;
      nb_waddr     = nb_idx_ff;
      nb_wdata     = nb_rd_ff;
      nb_raddr     = scan_ff[NbIdxW-1:0];
      far_we       = 1'b0;
      far_raddr    = scan_ff[FarIdxW-1:0];
      link_we      = 1'b0;
      link_waddr   = {nb_idx_ff, rd_lcnt[LinkIdxW-1:0]};
      link_raddr   = {nb_idx_ff, scan_ff[LinkIdxW-1:0]};
      scan_end     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            hit_in  = 1'b0;
            if (accept) begin
               if (mode_type'(req_tdata[1:0]) == MODE_NB_REPORT) state_in = S_MUL;
               else if (mode_type'(req_tdata[1:0]) == MODE_AGE_TICK) state_in = S_AGE_RD;
               else state_in = S_NB_SCAN;
            end
         end
         S_MUL: state_in = S_DIV;
         S_DIV: if (dcnt_ff == 6'd31) state_in = S_NB_SCAN;
         S_NB_SCAN: begin
            // Memory output of the previous address is compared in the cycle after its read.
            if (rd_pend_ff && rd_id == nid_ff) begin
               hit_in   = 1'b1;
               nb_raddr = nb_idx_ff;
               state_in = S_NB_DONE;
            end else if (scan_ff == nb_count_ff) begin
               state_in = S_NB_DONE;
            end else begin
               nb_idx_in  = scan_ff[NbIdxW-1:0];
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         S_NB_DONE: begin
            // nb_rd_ff holds the hit record, read again on the hit cycle.
            state_in = S_OUT;
            rsp_valid_in = 1'b1;
            cost_out_in  = 32'd0;
            st_in        = ST_OK;
            idx_out_in   = 4'(nb_idx_ff);
            case (mode_type'(mode_ff))
               MODE_NB_REPORT: begin
                  cost_out_in = cost_ff;
                  if (hit_ff) begin
                     nb_we    = 1'b1;
                     nb_wdata = {rd_id, cost_ff, rd_flags, rd_lcnt};
                  end else if (nb_full) begin
                     st_in = ST_FULL; idx_out_in = 4'd0;
                  end else begin
                     nb_we       = 1'b1;
                     nb_waddr    = nb_count_ff[NbIdxW-1:0];
                     nb_wdata    = {nid_ff, cost_ff, 2'b00, LinkCntW'(0)};
                     nb_count_in = nb_count_ff + 1'b1;
                     idx_out_in  = 4'(nb_count_ff);
                  end
               end
               MODE_MPR_NOTICE: begin
                  if (hit_ff) begin
                     nb_we    = 1'b1;
                     nb_wdata = {rd_id, rd_cost, rd_flags | 2'b10, rd_lcnt};
                  end else begin
                     st_in = ST_UNKNOWN; idx_out_in = 4'd0;
                  end
               end
               default: begin
                  if (!hit_ff) begin
                     st_in = ST_UNKNOWN; idx_out_in = 4'd0;
                  end else if (fid_ff == node_addr_ff) begin
                     st_in = ST_OWN_ADDR;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && !rsp_tready;
                     state_in = S_FAR_SCAN;
                     scan_in  = '0;
                     hit_in   = 1'b0;
                  end
               end
            endcase
         end
         S_FAR_SCAN: begin
            nb_raddr = nb_idx_ff; // keep sender record on the read port
            if (rd_pend_ff && far_rd_ff == fid_ff) begin
               hit_in   = 1'b1;
               state_in = S_FAR_DONE;
            end else if (scan_ff == NbCntW'(far_count_ff)) begin
               state_in = S_FAR_DONE;
            end else begin
               far_idx_in = scan_ff[FarIdxW-1:0];
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         S_FAR_DONE: begin
            nb_raddr = nb_idx_ff;
            scan_in  = '0;
            if (hit_ff) begin
               hit_in   = 1'b0;
               state_in = S_LINK_SCAN;
            end else if (far_full) begin
               st_in = ST_FULL; idx_out_in = 4'd0; cost_out_in = 32'd0;
               rsp_valid_in = 1'b1; state_in = S_OUT;
            end else begin
               far_we       = 1'b1;
               far_idx_in   = far_count_ff[FarIdxW-1:0];
               far_count_in = far_count_ff + 1'b1;
               state_in     = S_LINK_SCAN;
            end
         end
         S_LINK_SCAN: begin
            nb_raddr = nb_idx_ff;
            if (rd_pend_ff && link_rd_ff == far_idx_ff) begin
               hit_in   = 1'b1;
               state_in = S_LINK_DONE;
            end else if (scan_ff == NbCntW'(rd_lcnt)) begin
               state_in = S_LINK_DONE;
            end else begin
               scan_in    = scan_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
         end
         S_LINK_DONE: begin
            nb_raddr = nb_idx_ff;
            state_in = S_OUT;
            rsp_valid_in = 1'b1;
            cost_out_in  = 32'd0;
            st_in        = ST_OK;
            idx_out_in   = 4'(far_idx_ff);
            if (!hit_ff) begin
               if (rd_lcnt == LinkCntW'(LinksPerNeighbor)) begin
                  st_in = ST_FULL; idx_out_in = 4'd0;
               end else begin
                  link_we  = 1'b1;
                  nb_we    = 1'b1;
                  nb_wdata = {rd_id, rd_cost, rd_flags, rd_lcnt + 1'b1};
               end
            end
         end
         S_AGE_RD: begin
            nb_idx_in = scan_ff[NbIdxW-1:0];
            if (scan_ff == nb_count_ff) begin
               st_in = ST_OK; idx_out_in = 4'd0; cost_out_in = 32'd0;
               rsp_valid_in = 1'b1; state_in = S_OUT;
            end else begin
               state_in = S_AGE_WR;
            end
         end
         S_AGE_WR: begin
            nb_we   = 1'b1;
            scan_in = scan_ff + 1'b1;
            if (rd_cost < CostMax - AgeStep)
               nb_wdata = {rd_id, rd_cost + AgeStep, rd_flags, rd_lcnt};
            else
               nb_wdata = {rd_id, CostMax, 2'b00, LinkCntW'(0)};
            nb_raddr = scan_in[NbIdxW-1:0];
            state_in = S_AGE_RD;
         end
         S_OUT: if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_NB_SCAN || state_ff == S_AGE_RD) scan_end = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_addr_ff  <= 16'd0;
         energy_cap_ff <= CostMax;
         cost_mult_ff  <= 32'd1;
         link_delay_ff <= 32'd1;
         nb_count_ff   <= '0;
         far_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_pend_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nb_count_ff  <= nb_count_in;
         far_count_ff <= far_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_NODE_ADDRESS: node_addr_ff  <= csr_data[15:0];
               CSR_ENERGY_CAP:   energy_cap_ff <= csr_data;
               CSR_COST_MULT:    cost_mult_ff  <= csr_data;
               CSR_LINK_DELAY:   link_delay_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload and datapath
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      nb_idx_ff   <= nb_idx_in;
      far_idx_ff  <= far_idx_in;
      st_ff       <= st_in;
      idx_out_ff  <= idx_out_in;
      cost_out_ff <= cost_out_in;
      if (accept) begin
         mode_ff   <= req_tdata[1:0];
         nid_ff    <= req_tdata[17:2];
         energy_ff <= req_tdata[49:18];
         fid_ff    <= req_tdata[65:50];
      end
      if (state_ff == S_MUL) begin
         rem_ff  <= {32'd0, 32'(capped * cost_mult_ff)};
         dcnt_ff <= 6'd0;
      end else if (state_ff == S_DIV) begin
         // Restoring divide: rem_ff[63:32] partial remainder, low half quotient.
         dcnt_ff <= dcnt_ff + 6'd1;
         if (!dtrial[32])
            rem_ff <= {dtrial[31:0], rem_ff[30:0], 1'b1};
         else
            rem_ff <= {rem_ff[62:0], 1'b0};
         if (dcnt_ff == 6'd31) begin
            if (link_delay_ff == 32'd0) cost_ff <= CostMax;
            else cost_ff <= !dtrial[32] ? {rem_ff[30:0], 1'b1} : {rem_ff[30:0], 1'b0};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, cost_out_ff, idx_out_ff, st_ff};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("item accepted while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      nb_count_ff <= NbCntW'(MaxNeighbors) && far_count_ff <= FarCntW'(MaxFarNodes))
      else $error("table count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(nb_count_ff) |-> nb_count_ff == $past(nb_count_ff) + 1'b1 || scan_end)
      else $error("neighbor count jumped");
`endif
endmodule
`default_nettype wire
